// ----- hdl/bce_pkg.sv -----
package bce_pkg;

   // Field widths of the request and response words
   localparam int IDX_W = 5;
   localparam int PT_W  = 16;
   localparam int T_W   = 17;

   // Parameter t: unsigned Q1.16, clamped to one
   localparam int            T_FRAC = 16;
   localparam logic [T_W-1:0] T_ONE = 17'h1_0000;
   localparam int            T_HALF = 32768;

   // Bernstein weights: unsigned Q1.30, never above one
   localparam int             B_W    = 31;
   localparam logic [B_W-1:0] B_ONE  = 31'h4000_0000;
   localparam int             B_FRAC = 30;

   // Step product: signed t times weight difference
   localparam int MIX_W  = T_W + B_W + 2;
   // Weight times control point
   localparam int PROD_W = B_W + 1 + PT_W;

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [IDX_W-1:0]        point_index;
      logic signed [PT_W-1:0]  point_x;
      logic signed [PT_W-1:0]  point_y;
      logic [T_W-1:0]          t_value;
   } req_type;

   typedef struct packed {
      logic signed [PT_W-1:0] curve_x;
      logic signed [PT_W-1:0] curve_y;
   } rsp_type;

   // Shared controls from the sequencer to every cell
   typedef struct packed {
      logic                   load;
      logic                   step;
      logic [T_W-1:0]         t;
      logic signed [PT_W-1:0] wr_x;
      logic signed [PT_W-1:0] wr_y;
   } cell_ctrl_type;

endpackage

// ----- hdl/bce_stream_if.sv -----
interface bce_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bezier_curve_evaluator.sv -----
// Bezier curve evaluator, Bernstein form, degree DEGREE.
// req_if (sink) takes one word per handshake: mode 0 stores control point
// point_index as (point_x, point_y) in signed Q7.8; an index above DEGREE
// is dropped. Mode 1 evaluates the curve at t_value (unsigned Q1.16,
// clamped to 1.0) and returns one word on rsp_if (source) holding
// curve_x, curve_y in signed Q7.8, rounded and saturated.
// Timing: a write returns nothing; writes stream at one per cycle while
// the cell row is idle. An evaluate runs the recurrence steps over the row
// of DEGREE+1 cells, then waits while the partial sums ripple down the row,
// then rounds into the output register. No word is taken while an evaluate
// runs; the next word can be taken in the cycle that the result appears.
// The length of the cell row sets both phases.
// Reset clears all control points to zero and empties the output register.
// While a result waits on a stalled receiver the block still accepts
// writes and starts the next evaluate; that evaluate holds its finished
// sum until the output register is taken.
module bezier_curve_evaluator #(
   parameter int DEGREE = 20
) (
   input  logic               clock,
   input  logic               reset,
   bce_stream_if.sink         req_if,
   bce_stream_if.source       rsp_if
);

   localparam int NPTS  = DEGREE + 1;
   localparam int ACC_W = bce_pkg::PROD_W + $clog2(NPTS);
   localparam int CNT_W = $clog2(DEGREE + 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W+1)'(1) <<< (bce_pkg::B_FRAC - 1);
   localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] SAT_LO   = -SAT_HI - (ACC_W+1)'(1);

   // Round half up to Q8 (floor of sum plus one half) and clamp to 16 bits
   function automatic logic signed [bce_pkg::PT_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] q8;
      logic signed [bce_pkg::PT_W-1:0] res;
      biased = (ACC_W+1)'(acc) + ACC_HALF;
      q8     = biased >>> bce_pkg::B_FRAC;
      if (q8 > SAT_HI) begin
         res = bce_pkg::PT_W'(SAT_HI);
      end else if (q8 < SAT_LO) begin
         res = bce_pkg::PT_W'(SAT_LO);
      end else begin
         res = q8[bce_pkg::PT_W-1:0];
      end
      return res;
   endfunction

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [bce_pkg::T_W-1:0]   t_ff, t_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bce_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      out_free;
   bce_pkg::cell_ctrl_type    ctrl;
   logic [NPTS-1:0]           wr_en;

   logic [bce_pkg::B_W-1:0]   b_chain   [NPTS];
   logic signed [ACC_W-1:0]   psx_chain [NPTS];
   logic signed [ACC_W-1:0]   psy_chain [NPTS];

   // Take words only while the cell row is free
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Clamp t to one on the way in
   assign t_in = (req_if.data.t_value > bce_pkg::T_ONE) ? bce_pkg::T_ONE
                                                        : req_if.data.t_value;

   always_comb begin
      ctrl.load = req_fire && (req_if.data.mode == bce_pkg::MODE_EVAL);
      ctrl.step = (state_ff == ST_STEP);
      ctrl.t    = t_ff;
      ctrl.wr_x = req_if.data.point_x;
      ctrl.wr_y = req_if.data.point_y;
   end

   // Sequencer: load weights, step the recurrence, let the sums settle, wait for the output slot
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) begin
               state_in = ST_STEP;
               cnt_in   = '0;
            end
         end
         ST_STEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DEGREE - 1)) begin
               state_in = ST_SUM;
               cnt_in   = '0;
            end
         end
         ST_SUM: begin
            // wait here until the last cell's sum is complete after the final step
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DEGREE + 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load when the sum is done and the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.curve_x = round_sat(psx_chain[DEGREE]);
         rsp_data_in.curve_y = round_sat(psy_chain[DEGREE]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (ctrl.load) begin
         t_ff <= t_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Row of cells: cell i holds control point i and weight i
   for (genvar i = 0; i < NPTS; i++) begin : g_cell
      logic [bce_pkg::B_W-1:0] seed;
      logic [bce_pkg::B_W-1:0] b_left;
      logic signed [ACC_W-1:0] psx_left;
      logic signed [ACC_W-1:0] psy_left;

      // a write beyond the degree matches no cell and is dropped
      assign wr_en[i] = req_fire && (req_if.data.mode == bce_pkg::MODE_WRITE) &&
                        (req_if.data.point_index == bce_pkg::IDX_W'(i));

      if (i == 0) begin : g_head
         assign seed     = bce_pkg::B_ONE;
         assign b_left   = '0;
         assign psx_left = '0;
         assign psy_left = '0;
      end else begin : g_body
         assign seed     = '0;
         assign b_left   = b_chain[i-1];
         assign psx_left = psx_chain[i-1];
         assign psy_left = psy_chain[i-1];
      end

      bce_cell #(
         .ACC_W (ACC_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_en    (wr_en[i]),
         .b_seed   (seed),
         .b_left   (b_left),
         .psx_left (psx_left),
         .psy_left (psy_left),
         .b_out    (b_chain[i]),
         .psx_out  (psx_chain[i]),
         .psy_out  (psy_chain[i])
      );
   end

endmodule

// ----- hdl/bce_cell.sv -----
module bce_cell #(
   parameter int ACC_W = 53
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bce_pkg::cell_ctrl_type         ctrl,
   input  logic                           wr_en,
   input  logic [bce_pkg::B_W-1:0]        b_seed,
   input  logic [bce_pkg::B_W-1:0]        b_left,
   input  logic signed [ACC_W-1:0]        psx_left,
   input  logic signed [ACC_W-1:0]        psy_left,
   output logic [bce_pkg::B_W-1:0]        b_out,
   output logic signed [ACC_W-1:0]        psx_out,
   output logic signed [ACC_W-1:0]        psy_out
);

   logic [bce_pkg::B_W-1:0]          b_ff, b_in;
   logic signed [bce_pkg::PT_W-1:0]  px_ff, py_ff;
   logic signed [bce_pkg::PROD_W-1:0] prodx_ff, prody_ff, prodx_in, prody_in;
   logic signed [ACC_W-1:0]          psx_ff, psy_ff, psx_in, psy_in;

   logic signed [bce_pkg::B_W:0]      diff;
   logic signed [bce_pkg::MIX_W-1:0]  mix, mix_rnd, adj;

   // b' = b + round(t * (b_left - b)), same as u*b + t*b_left in Q30
   assign diff    = $signed({1'b0, b_left}) - $signed({1'b0, b_ff});
   assign mix     = bce_pkg::MIX_W'($signed({1'b0, ctrl.t})) * bce_pkg::MIX_W'(diff);
   assign mix_rnd = mix + bce_pkg::MIX_W'(bce_pkg::T_HALF);
   assign adj     = mix_rnd >>> bce_pkg::T_FRAC;

   always_comb begin
      b_in = b_ff;
      if (ctrl.load) begin
         b_in = b_seed;
      end else if (ctrl.step) begin
         b_in = b_ff + adj[bce_pkg::B_W-1:0];
      end
   end

   // Weighted partial sums ripple along the row, one cell per cycle
   assign prodx_in = bce_pkg::PROD_W'($signed({1'b0, b_ff})) * bce_pkg::PROD_W'(px_ff);
   assign prody_in = bce_pkg::PROD_W'($signed({1'b0, b_ff})) * bce_pkg::PROD_W'(py_ff);
   assign psx_in   = psx_left + ACC_W'(prodx_ff);
   assign psy_in   = psy_left + ACC_W'(prody_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
      end else if (wr_en) begin
         px_ff <= ctrl.wr_x;
         py_ff <= ctrl.wr_y;
      end
   end

   always_ff @(posedge clock) begin
      b_ff     <= b_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      psx_ff   <= psx_in;
      psy_ff   <= psy_in;
   end

   assign b_out   = b_ff;
   assign psx_out = psx_ff;
   assign psy_out = psy_ff;

endmodule
